FILE: rtl/modular_inverse_ext_euclid_top_macros.svh
// Assertion macros shared by the modular inverse RTL.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef MODULAR_INVERSE_EXT_EUCLID_TOP_MACROS_SVH
`define MODULAR_INVERSE_EXT_EUCLID_TOP_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted.
`define MIE_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MIE_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`else

`define MIE_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg)
`define MIE_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg)

`endif

`endif

FILE: rtl/mie_pkg.sv
// Shared types and constants for the modular inverse block.
// No dependencies; used by the top module of the block.
package mie_pkg;

	// Default operand width of the arithmetic datapath.
	localparam int unsigned WORD_BITS_DEF = 32;

	// Fixed width of the value fields on the ports.
	localparam int unsigned FIELD_BITS = 32;

	// Result status codes.
	localparam logic [1:0] STATUS_OK          = 2'd0;
	localparam logic [1:0] STATUS_NOT_COPRIME = 2'd1;
	localparam logic [1:0] STATUS_BAD_MODULUS = 2'd2;

	// Request beat: the number and the modulus.
	typedef struct packed {
		logic [FIELD_BITS-1:0] value;
		logic [FIELD_BITS-1:0] modulus;
	} req_beat_t;

	// Response beat: the inverse, the gcd and the status.
	typedef struct packed {
		logic [FIELD_BITS-1:0] inverse;
		logic [FIELD_BITS-1:0] gcd_value;
		logic [1:0]            status;
	} rsp_beat_t;

endpackage

FILE: rtl/mie_div.sv
// Restoring serial divider: one quotient bit per cycle.
// Depends on the assertion macro header only.
`include "modular_inverse_ext_euclid_top_macros.svh"

module mie_div #(
	parameter int unsigned W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         busy,
	output logic         done,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);

	localparam int unsigned CW = $clog2(W + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dvs_q;

	logic [W:0]    shifted;
	logic [W:0]    diff;
	logic          fits;

	// Trial subtraction of the divisor from the partial remainder.
	always_comb begin
		shifted = {rem_q, quo_q[W-1]};
		diff    = shifted - {1'b0, dvs_q};
		fits    = !diff[W];
	end

	// Control: bit counter, busy and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the dividend shifts out as the quotient shifts in.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[W-1:0] : shifted[W-1:0];
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

	`MIE_ASSERT_NEXT(a_div_done_pulse, clk, arst_n, done_q, !done_q, "divider done held")

endmodule

FILE: rtl/mie_mac.sv
// Serial shift-and-add multiply-accumulate: result = addend + mcand * mplier.
// Depends on the assertion macro header only.
`include "modular_inverse_ext_euclid_top_macros.svh"

module mie_mac #(
	parameter int unsigned W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] addend,
	input  logic [W-1:0] mcand,
	input  logic [W-1:0] mplier,
	output logic         busy,
	output logic         done,
	output logic [W-1:0] result
);

	logic         busy_q;
	logic         done_q;
	logic [W-1:0] acc_q;
	logic [W-1:0] mc_q;
	logic [W-1:0] mp_q;
	logic         last;

	// The run ends once no set multiplier bit is left above the current one.
	assign last = (mp_q[W-1:1] == '0);

	// Control: busy until the multiplier is used up.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && last) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Datapath: multiplier bits taken from the bottom, multiplicand shifted up.
	// Shifted-out multiplicand bits only matter when the product overflows,
	// which the caller's bounds rule out.
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= addend;
			mc_q  <= mcand;
			mp_q  <= mplier;
		end else if (busy_q) begin
			if (mp_q[0]) begin
				acc_q <= acc_q + mc_q;
			end
			mc_q <= {mc_q[W-2:0], 1'b0};
			mp_q <= {1'b0, mp_q[W-1:1]};
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = acc_q;

	`MIE_ASSERT_IMP(a_mac_done_idle, clk, arst_n, done_q, !busy_q, "mac done while busy")

endmodule

FILE: rtl/modular_inverse_ext_euclid_top.sv
// Each request passes S_IDLE, S_CHECK and S_OUT; each Euclid step adds a division in S_DIV
// and a multiply-add in S_MUL, and a final reduction division in S_MOD follows when the gcd
// is one.
// Throughput: one beat at a time; the serial divider and multiplier set the rate.
// Reset clears the sequencer and the response valid; no clearing pass.
// Depends on mie_pkg, mie_div, mie_mac and the assertion macro header.
`include "modular_inverse_ext_euclid_top_macros.svh"

module modular_inverse_ext_euclid_top #(
	parameter int unsigned WORD_BITS = mie_pkg::WORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  mie_pkg::req_beat_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output mie_pkg::rsp_beat_t rsp
);

	localparam int unsigned WB = WORD_BITS;
	localparam int unsigned FB = mie_pkg::FIELD_BITS;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_DIV,
		S_MUL,
		S_MOD,
		S_OUT
	} state_t;

	state_t             state_q;
	logic [WB-1:0]      r0_q;
	logic [WB-1:0]      r1_q;
	logic [WB-1:0]      c0_q;
	logic [WB-1:0]      c1_q;
	logic [WB-1:0]      n_q;
	logic               par_q;
	logic [WB-1:0]      inv_q;
	logic [WB-1:0]      g_q;
	logic [1:0]         st_q;
	logic               div_start_q;
	logic [WB-1:0]      div_a_q;
	logic [WB-1:0]      div_b_q;
	logic               mac_start_q;
	logic [WB-1:0]      mac_add_q;
	logic [WB-1:0]      mac_mc_q;
	logic [WB-1:0]      mac_mp_q;
	logic               rsp_valid_q;
	mie_pkg::rsp_beat_t rsp_q;

	logic               div_busy;
	logic               div_done;
	logic [WB-1:0]      div_quo;
	logic [WB-1:0]      div_rem;
	logic               mac_busy;
	logic               mac_done;
	logic [WB-1:0]      mac_res;

	logic [WB+FB-1:0]   a_wide;
	logic [WB+FB-1:0]   n_wide;
	logic [WB+FB-1:0]   inv_wide;
	logic [WB+FB-1:0]   g_wide;
	logic               n_small;
	logic [WB-1:0]      mod_inv;

	// Input fields resized to the datapath width.
	assign a_wide = {{WB{1'b0}}, req.value};
	assign n_wide = {{WB{1'b0}}, req.modulus};

	// Results resized to the port width.
	assign inv_wide = {{FB{1'b0}}, inv_q};
	assign g_wide   = {{FB{1'b0}}, g_q};

	// Modulus below two.
	assign n_small = (n_q[WB-1:1] == '0);

	// Final reduction: the coefficient is negative after an even step count.
	assign mod_inv = (!par_q && (div_rem != '0)) ? (n_q - div_rem) : div_rem;

	mie_div #(
		.W (WB)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start_q),
		.dividend  (div_a_q),
		.divisor   (div_b_q),
		.busy      (div_busy),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	mie_mac #(
		.W (WB)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start_q),
		.addend (mac_add_q),
		.mcand  (mac_mc_q),
		.mplier (mac_mp_q),
		.busy   (mac_busy),
		.done   (mac_done),
		.result (mac_res)
	);

	// Sequencer: one Euclid step is a division followed by a multiply-add.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			r0_q        <= '0;
			r1_q        <= '0;
			c0_q        <= '0;
			c1_q        <= '0;
			n_q         <= '0;
			par_q       <= 1'b0;
			inv_q       <= '0;
			g_q         <= '0;
			st_q        <= mie_pkg::STATUS_OK;
			div_start_q <= 1'b0;
			div_a_q     <= '0;
			div_b_q     <= '0;
			mac_start_q <= 1'b0;
			mac_add_q   <= '0;
			mac_mc_q    <= '0;
			mac_mp_q    <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			div_start_q <= 1'b0;
			mac_start_q <= 1'b0;
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						r0_q    <= n_wide[WB-1:0];
						r1_q    <= a_wide[WB-1:0];
						n_q     <= n_wide[WB-1:0];
						c0_q    <= '0;
						c1_q    <= WB'(1);
						par_q   <= 1'b0;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (r1_q != '0) begin
						div_start_q <= 1'b1;
						div_a_q     <= r0_q;
						div_b_q     <= r1_q;
						state_q     <= S_DIV;
					end else if (!n_small && (r0_q == WB'(1))) begin
						div_start_q <= 1'b1;
						div_a_q     <= c0_q;
						div_b_q     <= n_q;
						state_q     <= S_MOD;
					end else begin
						inv_q   <= '0;
						g_q     <= r0_q;
						st_q    <= n_small ? mie_pkg::STATUS_BAD_MODULUS
						                   : mie_pkg::STATUS_NOT_COPRIME;
						state_q <= S_OUT;
					end
				end
				S_DIV: begin
					if (div_done) begin
						r0_q        <= r1_q;
						r1_q        <= div_rem;
						mac_start_q <= 1'b1;
						mac_add_q   <= c0_q;
						mac_mc_q    <= c1_q;
						mac_mp_q    <= div_quo;
						state_q     <= S_MUL;
					end
				end
				S_MUL: begin
					if (mac_done) begin
						c0_q    <= c1_q;
						c1_q    <= mac_res;
						par_q   <= !par_q;
						state_q <= S_CHECK;
					end
				end
				S_MOD: begin
					if (div_done) begin
						inv_q   <= mod_inv;
						g_q     <= r0_q;
						st_q    <= mie_pkg::STATUS_OK;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q     <= 1'b1;
						rsp_q.inverse   <= inv_wide[FB-1:0];
						rsp_q.gcd_value <= g_wide[FB-1:0];
						rsp_q.status    <= st_q;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`MIE_ASSERT_IMP(a_ready_units_idle, clk, arst_n, req_ready, !div_busy && !mac_busy, "accepting while units busy")
	`MIE_ASSERT_IMP(a_div_done_expected, clk, arst_n, div_done, (state_q == S_DIV) || (state_q == S_MOD), "unexpected divider completion")
	`MIE_ASSERT_IMP(a_ok_gcd_one, clk, arst_n, rsp_valid_q && (rsp_q.status == mie_pkg::STATUS_OK), rsp_q.gcd_value == FB'(1), "ok status without unit gcd")
	`MIE_ASSERT_IMP(a_fail_inv_zero, clk, arst_n, rsp_valid_q && (rsp_q.status != mie_pkg::STATUS_OK), rsp_q.inverse == '0, "nonzero inverse on failure")

endmodule
